[sv/dual_encoder_motor_step_controller_macros.svh]
// Assertion helpers shared by the controller RTL.
// Both forms are clocked on aclk and are held off while aresetn is low.
`ifndef DUAL_ENCODER_MOTOR_STEP_CONTROLLER_MACROS_SVH
`define DUAL_ENCODER_MOTOR_STEP_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define DEMSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Consequent must hold in the cycle after the antecedent.
`define DEMSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`else

`define DEMSC_ASSERT_SAME(label, ante, cons)
`define DEMSC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/demsc_pkg.sv]
package demsc_pkg;

    // Basic widths.
    typedef logic [15:0]        pos_t;
    typedef logic signed [16:0] steps_t;

    // Item opcodes; the unused code behaves as a plain update.
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_FWD    = 2'd1;
    localparam logic [1:0] OP_BWD    = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FB_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_SPEED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REV_MASK   = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [15:0] RST_RESOLUTION = 16'd1024;
    localparam logic [7:0]  RST_BASE_SPEED = 8'd200;
    localparam logic [13:0] RST_FB_OFFSET  = 14'd2;
    localparam logic [7:0]  RST_FB_SPEED   = 8'd60;
    localparam logic [1:0]  RST_REV_MASK   = 2'd0;

    // Speed correction toward the other motor.
    localparam logic [9:0] SYNC_ADJ = 10'd20;

    typedef struct packed {
        logic [15:0] encoder_resolution;
        logic [7:0]  base_speed;
        logic [13:0] dead_band;
        logic [7:0]  return_duty;
        logic [1:0]  reversed_mask;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        motor_select;
        logic [15:0] step_count;
        logic        encoder_a;
        logic        encoder_b;
        logic        brake_only;
    } item_t;

    typedef struct packed {
        logic        motor_index;
        logic        dir_pin_one;
        logic        dir_pin_two;
        logic [7:0]  pwm_duty;
        logic [15:0] position;
        logic        move_done;
        logic        in_sync;
    } result_t;

endpackage

[sv/demsc_update.sv]
module demsc_update (
    input  demsc_pkg::item_t         item,
    input  demsc_pkg::cfg_t          cfg,
    input  demsc_pkg::pos_t   [1:0]  pos_cur,
    input  demsc_pkg::steps_t [1:0]  steps_cur,
    output demsc_pkg::pos_t   [1:0]  pos_new,
    output demsc_pkg::steps_t [1:0]  steps_new,
    output demsc_pkg::result_t       result
);
    import demsc_pkg::*;

    logic        sel;
    logic        oth;
    logic        rev;
    logic [16:0] res_ext;
    logic [16:0] load_mag;
    steps_t      count;
    steps_t      count_oth;
    steps_t      count_next;
    pos_t        pos_sel;
    pos_t        pos_upd;
    logic [16:0] pos_inc;
    pos_t [1:0]  pos_all;
    logic signed [9:0] speed;
    logic [7:0]  speed_sat;
    logic [15:0] half;
    logic signed [17:0] res_minus_off;
    logic        fwd_zone;
    logic        bwd_zone;
    logic signed [16:0] pos_diff;
    logic [15:0] diff_abs;
    logic signed [16:0] wrap_diff;
    logic [15:0] wrap_abs;
    logic [15:0] thr;

    assign sel     = item.motor_select;
    assign oth     = ~item.motor_select;
    assign rev     = cfg.reversed_mask[sel];
    assign res_ext = {1'b0, cfg.encoder_resolution};

    // A command loads the remaining count; zero means one full turn.
    assign load_mag = (item.step_count == 16'd0) ? res_ext : {1'b0, item.step_count};

    always_comb begin
        case (item.opcode)
            OP_FWD:  count = steps_t'(load_mag);
            OP_BWD:  count = -steps_t'(load_mag);
            default: count = steps_cur[sel];
        endcase
    end

    assign count_oth = steps_cur[oth];

    // Encoder position counts up on equal levels and down otherwise, with wrap.
    assign pos_sel = pos_cur[sel];
    assign pos_inc = {1'b0, pos_sel} + 17'd1;

    always_comb begin
        if (item.encoder_a == item.encoder_b) begin
            pos_upd = (pos_inc >= res_ext) ? 16'd0 : pos_inc[15:0];
        end else begin
            pos_upd = (pos_sel == 16'd0) ? (cfg.encoder_resolution - 16'd1)
                                         : (pos_sel - 16'd1);
        end
    end

    always_comb begin
        pos_all      = pos_cur;
        pos_all[sel] = pos_upd;
    end

    assign pos_new = pos_all;

    // Base speed nudged toward the other motor's remaining count, then clamped.
    always_comb begin
        speed = signed'({2'b00, cfg.base_speed});
        if (count > count_oth) begin
            speed = speed - signed'(SYNC_ADJ);
        end else if (count < count_oth) begin
            speed = speed + signed'(SYNC_ADJ);
        end
        if (speed < 10'sd0) begin
            speed_sat = 8'd0;
        end else if (speed > 10'sd255) begin
            speed_sat = 8'd255;
        end else begin
            speed_sat = speed[7:0];
        end
    end

    // Return-to-zero windows on either side of the half turn.
    assign half          = cfg.encoder_resolution >> 1;
    assign res_minus_off = signed'({2'b00, cfg.encoder_resolution})
                         - signed'({4'b0000, cfg.dead_band});
    assign fwd_zone = (pos_upd >= {2'b00, cfg.dead_band}) && (pos_upd < half);
    assign bwd_zone = (signed'({2'b00, pos_upd}) <= res_minus_off) && (pos_upd >= half);

    // Drive while steps remain, otherwise brake or return to zero.
    always_comb begin
        result.motor_index = sel;
        result.position    = pos_upd;
        count_next         = count;
        if (count > 17'sd0) begin
            result.dir_pin_one = ~rev;
            result.dir_pin_two = rev;
            result.pwm_duty    = speed_sat;
            count_next         = count - 17'sd1;
        end else if (count < 17'sd0) begin
            result.dir_pin_one = rev;
            result.dir_pin_two = ~rev;
            result.pwm_duty    = speed_sat;
            count_next         = count + 17'sd1;
        end else begin
            result.dir_pin_one = 1'b1;
            result.dir_pin_two = 1'b1;
            result.pwm_duty    = 8'd0;
            if (!item.brake_only && fwd_zone) begin
                result.dir_pin_one = 1'b1;
                result.dir_pin_two = 1'b0;
                result.pwm_duty    = cfg.return_duty;
            end else if (!item.brake_only && bwd_zone) begin
                result.dir_pin_one = 1'b0;
                result.dir_pin_two = 1'b1;
                result.pwm_duty    = cfg.return_duty;
            end
        end
        result.move_done = (count_next == 17'sd0);
        result.in_sync   = (diff_abs < thr) || (wrap_abs < thr);
    end

    always_comb begin
        steps_new      = steps_cur;
        steps_new[sel] = count_next;
    end

    // Sync test on the updated positions, also across the wrap point.
    assign pos_diff  = signed'({1'b0, pos_all[0]}) - signed'({1'b0, pos_all[1]});
    assign diff_abs  = pos_diff[16] ? 16'(-pos_diff) : pos_diff[15:0];
    assign wrap_diff = signed'({1'b0, diff_abs}) - signed'(res_ext);
    assign wrap_abs  = wrap_diff[16] ? 16'(-wrap_diff) : wrap_diff[15:0];
    assign thr       = {cfg.dead_band, 2'b00};

endmodule

[sv/dual_encoder_motor_step_controller.sv]
// Two-motor encoder step controller. Each item on the s_ channel names one motor,
// optionally loads a forward or backward step count, advances that motor's encoder
// position and yields one drive result on the m_ channel. An item is captured in an
// input register and its whole update runs from there into the result register, which
// waits while an earlier result is not yet taken; one item can be taken every cycle
// while m_ready stays high, and the position and step count state is written back
// in the same cycle as the result, so each item sees the effect of
// the one before it. The output register lets a new item enter while a result
// still waits for m_ready.
// Configuration writes through cfg_wr_en take effect on the next item and belong
// in idle periods; unknown register indexes are ignored.
`include "dual_encoder_motor_step_controller_macros.svh"

module dual_encoder_motor_step_controller (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration port
    input  logic                                 cfg_wr_en,
    input  logic [demsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [demsc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // Input item channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_opcode,
    input  logic                                 s_motor_select,
    input  logic [15:0]                          s_step_count,
    input  logic                                 s_encoder_a,
    input  logic                                 s_encoder_b,
    input  logic                                 s_brake_only,
    // Result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_motor_index,
    output logic                                 m_dir_pin_one,
    output logic                                 m_dir_pin_two,
    output logic [7:0]                           m_pwm_duty,
    output logic [15:0]                          m_position,
    output logic                                 m_move_done,
    output logic                                 m_in_sync
);
    import demsc_pkg::*;

    cfg_t              cfg_reg;
    item_t             in_item_reg;
    logic              in_vld_reg;
    result_t           out_res_reg;
    logic              out_vld_reg;
    pos_t   [1:0]      pos_reg;
    steps_t [1:0]      steps_reg;
    pos_t   [1:0]      pos_next;
    steps_t [1:0]      steps_next;
    result_t           res_next;
    item_t             s_item;
    logic              s_fire;
    logic              upd_fire;

    assign s_item = '{opcode:       s_opcode,
                      motor_select: s_motor_select,
                      step_count:   s_step_count,
                      encoder_a:    s_encoder_a,
                      encoder_b:    s_encoder_b,
                      brake_only:   s_brake_only};

    // The update runs when an item is held and the result register is free.
    assign upd_fire = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready  = !in_vld_reg || upd_fire;
    assign s_fire   = s_valid && s_ready;

    demsc_update u_update (
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .pos_cur   (pos_reg),
        .steps_cur (steps_reg),
        .pos_new   (pos_next),
        .steps_new (steps_next),
        .result    (res_next)
    );

    // Control state, configuration and motor state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            cfg_reg     <= '{encoder_resolution: RST_RESOLUTION,
                             base_speed:         RST_BASE_SPEED,
                             dead_band:          RST_FB_OFFSET,
                             return_duty:        RST_FB_SPEED,
                             reversed_mask:      RST_REV_MASK};
            pos_reg     <= '0;
            steps_reg   <= '0;
        end else begin
            if (s_fire) begin
                in_vld_reg <= 1'b1;
            end else if (upd_fire) begin
                in_vld_reg <= 1'b0;
            end
            if (upd_fire) begin
                out_vld_reg <= 1'b1;
                pos_reg     <= pos_next;
                steps_reg   <= steps_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_RESOLUTION: cfg_reg.encoder_resolution <= cfg_wr_data;
                    REG_BASE_SPEED: cfg_reg.base_speed         <= cfg_wr_data[7:0];
                    REG_FB_OFFSET:  cfg_reg.dead_band          <= cfg_wr_data[13:0];
                    REG_FB_SPEED:   cfg_reg.return_duty        <= cfg_wr_data[7:0];
                    REG_REV_MASK:   cfg_reg.reversed_mask      <= cfg_wr_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (upd_fire) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_motor_index = out_res_reg.motor_index;
    assign m_dir_pin_one = out_res_reg.dir_pin_one;
    assign m_dir_pin_two = out_res_reg.dir_pin_two;
    assign m_pwm_duty    = out_res_reg.pwm_duty;
    assign m_position    = out_res_reg.position;
    assign m_move_done   = out_res_reg.move_done;
    assign m_in_sync     = out_res_reg.in_sync;

    // An update always leaves a result behind it.
    `DEMSC_ASSERT_NEXT(a_update_gives_result, upd_fire, out_vld_reg)
    // A held item that cannot move on stays put.
    `DEMSC_ASSERT_NEXT(a_held_item_stable, in_vld_reg && !upd_fire,
                       in_vld_reg && $stable(in_item_reg))
    // Input back-pressure only comes from a full stage behind a stalled result.
    `DEMSC_ASSERT_SAME(a_ready_low_cause, !s_ready, in_vld_reg && out_vld_reg && !m_ready)
    // Braking pins come with zero duty.
    `DEMSC_ASSERT_NEXT(a_brake_zero_duty,
                       upd_fire && res_next.dir_pin_one && res_next.dir_pin_two,
                       m_pwm_duty == 8'd0)
    // The count never moves without an item being processed.
    `DEMSC_ASSERT_NEXT(a_state_holds, !upd_fire, $stable(steps_reg) && $stable(pos_reg))

endmodule
